FILE: rtl/dcc_pkg.sv
// shared types, codes and constants of the dwell-click controller
package dcc_pkg;

    // field widths
    localparam int DWELL_W = 16;
    localparam int SENS_W  = 10;
    localparam int REP_W   = 5;
    localparam int POS_W   = 16;
    localparam int TIME_W  = 32;
    localparam int TYPE_W  = 4;
    localparam int MOD_W   = 8;
    localparam int PROG_W  = 9;
    localparam int QUO_W   = 8;
    localparam int CFG_IDX_W = 2;

    // fixed limits
    localparam logic [TIME_W-1:0] DRAG_HOLD_LIMIT_MS = 32'd10000;
    localparam int MAX_SCROLL_REPEAT = 16;
    localparam int REPEAT_CAP = (MAX_SCROLL_REPEAT < 16) ? MAX_SCROLL_REPEAT : 16;

    // register reset values
    localparam logic [DWELL_W-1:0] DWELL_RESET  = 16'd1000;
    localparam logic [SENS_W-1:0]  SENS_RESET   = 10'd10;
    localparam logic [REP_W-1:0]   REPEAT_RESET = 5'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SENS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT = 2'd2;

    // command codes
    localparam logic [1:0] CMD_POLL   = 2'd0;
    localparam logic [1:0] CMD_ARM    = 2'd1;
    localparam logic [1:0] CMD_DISARM = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_PROGRESS = 2'd0;
    localparam logic [1:0] KIND_CLICK    = 2'd1;
    localparam logic [1:0] KIND_ABOUT    = 2'd2;
    localparam logic [1:0] KIND_FIRED    = 2'd3;

    // click types
    localparam logic [TYPE_W-1:0] TYPE_LEFT_DOWN  = 4'd0;
    localparam logic [TYPE_W-1:0] TYPE_LEFT_UP    = 4'd1;
    localparam logic [TYPE_W-1:0] TYPE_RIGHT_DOWN = 4'd2;
    localparam logic [TYPE_W-1:0] TYPE_RIGHT_UP   = 4'd3;

    localparam logic [PROG_W-1:0] PROG_FULL = 9'd256;

    typedef struct packed {
        logic [1:0]               command;
        logic signed [POS_W-1:0]  cursor_x;
        logic signed [POS_W-1:0]  cursor_y;
        logic [TIME_W-1:0]        now_ms;
        logic [TYPE_W-1:0]        arm_type;
        logic [MOD_W-1:0]         arm_modifiers;
    } in_item_t;

    typedef struct packed {
        logic [1:0]               kind;
        logic [TYPE_W-1:0]        out_type;
        logic [MOD_W-1:0]         out_modifiers;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic [PROG_W-1:0]        progress;
        logic                     last;
    } out_item_t;

    // classified request as queued between front and back
    typedef struct packed {
        logic                     is_arm;
        logic                     is_disarm;
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic [TIME_W-1:0]        now_ms;
        logic [TYPE_W-1:0]        arm_type;
        logic [MOD_W-1:0]         arm_mods;
    } dec_item_t;

    typedef struct packed {
        logic [DWELL_W-1:0] dwell_ms;
        logic [SENS_W-1:0]  sensitivity_px;
        logic [REP_W-1:0]   scroll_repeat;
    } cfg_t;

endpackage

FILE: rtl/dcc_front.sv
// front end: accepts requests, classifies the command and queues them for the back end
module dcc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dcc_pkg::in_item_t s_data,
    output logic              q_valid,
    output dcc_pkg::dec_item_t q_item,
    input  logic              q_pop
);
    import dcc_pkg::*;

    localparam int QDEPTH = 2;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    dec_item_t              entry_reg [QDEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    dec_item_t              dec;
    logic                   push;
    logic                   keep;

    // classify: the unused command code is taken and dropped
    always_comb begin
        keep          = (s_data.command == CMD_POLL) || (s_data.command == CMD_ARM) ||
                        (s_data.command == CMD_DISARM);
        dec.is_arm    = (s_data.command == CMD_ARM);
        dec.is_disarm = (s_data.command == CMD_DISARM);
        dec.x         = s_data.cursor_x;
        dec.y         = s_data.cursor_y;
        dec.now_ms    = s_data.now_ms;
        dec.arm_type  = s_data.arm_type;
        dec.arm_mods  = s_data.arm_modifiers;
    end

    assign s_ready = (count_reg != CNT_W'(QDEPTH));
    assign push    = s_valid && s_ready && keep;
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];

    // queue pointers
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (q_pop && q_valid) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !(q_pop && q_valid)) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop && q_valid) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

FILE: rtl/dcc_div.sv
// radix-2 divider for the progress fraction, one quotient bit per cycle
module dcc_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [dcc_pkg::DWELL_W-1:0] numer,
    input  logic [dcc_pkg::DWELL_W-1:0] denom,
    output logic                        done,
    output logic [dcc_pkg::QUO_W-1:0]   quo
);
    import dcc_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DWELL_W-1:0]   rem_reg, rem_next;
    logic [DWELL_W-1:0]   den_reg, den_next;
    logic [QUO_W-1:0]     quo_reg, quo_next;
    logic [DWELL_W:0]     rem2;
    logic                 ge;

    // one restoring step: the remainder stays below the divisor
    assign rem2 = {rem_reg, 1'b0};
    assign ge   = (rem2 >= {1'b0, den_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = numer;
            den_next  = denom;
        end else if (busy_reg) begin
            rem_next = ge ? DWELL_W'(rem2 - {1'b0, den_reg}) : rem2[DWELL_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(QUO_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

FILE: rtl/dcc_back.sv
// back end: dwell state machine, distance and time tests, result sequencing
module dcc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  dcc_pkg::cfg_t       cfg,
    input  logic                q_valid,
    input  dcc_pkg::dec_item_t  q_item,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output dcc_pkg::out_item_t  m_data
);
    import dcc_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SQ    = 10'b0000000010,
        S_DEC   = 10'b0000000100,
        S_DIV   = 10'b0000001000,
        S_REL   = 10'b0000010000,
        S_PROG  = 10'b0000100000,
        S_ABOUT = 10'b0001000000,
        S_CLICK = 10'b0010000000,
        S_FIRED = 10'b0100000000,
        S_ZERO  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // dwell state
    logic                     armed_reg, armed_next;
    logic                     waiting_reg, waiting_next;
    logic                     hovering_reg, hovering_next;
    logic                     drag_held_reg, drag_held_next;
    logic [TYPE_W-1:0]        cur_type_reg, cur_type_next;
    logic [MOD_W-1:0]         cur_mods_reg, cur_mods_next;
    logic signed [POS_W-1:0]  anchor_x_reg, anchor_x_next;
    logic signed [POS_W-1:0]  anchor_y_reg, anchor_y_next;
    logic [TIME_W-1:0]        hover_start_reg, hover_start_next;
    logic [TIME_W-1:0]        wait_start_reg, wait_start_next;
    logic [TIME_W-1:0]        drag_start_reg, drag_start_next;

    // working registers of the request in flight
    dec_item_t                it_reg, it_next;
    logic [31:0]              dx2_reg, dx2_next;
    logic [31:0]              dy2_reg, dy2_next;
    logic [2*SENS_W-1:0]      ss_reg, ss_next;
    logic                     timed_reg, timed_next;
    logic                     drag_to_reg, drag_to_next;
    logic                     fire_reg, fire_next;
    logic [DWELL_W-1:0]       el_reg, el_next;
    logic [TYPE_W-1:0]        em_type_reg, em_type_next;
    logic [MOD_W-1:0]         em_mods_reg, em_mods_next;
    logic [PROG_W-1:0]        prog_reg, prog_next;
    logic                     prog_last_reg, prog_last_next;
    logic                     rel_zero_reg, rel_zero_next;
    logic [REP_W-1:0]         rep_reg, rep_next;

    // output register
    logic                     m_valid_reg;
    out_item_t                m_data_reg;
    out_item_t                res;
    logic                     out_load;
    logic                     out_free;

    // stage arithmetic
    logic signed [POS_W:0]    dx, dy;
    logic signed [2*POS_W+1:0] dx_sq, dy_sq;
    logic [TIME_W-1:0]        e_wait, e_drag, e_hover;
    logic [33:0]              dsum;
    logic                     far, moved;
    logic [REP_W-1:0]         reps;

    logic                     div_start;
    logic                     div_done;
    logic [QUO_W-1:0]         div_quo;

    dcc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (el_reg),
        .denom   (cfg.dwell_ms),
        .done    (div_done),
        .quo     (div_quo)
    );

    // squares and elapsed times of the request in flight
    always_comb begin
        dx      = $signed({it_reg.x[POS_W-1], it_reg.x}) -
                  $signed({anchor_x_reg[POS_W-1], anchor_x_reg});
        dy      = $signed({it_reg.y[POS_W-1], it_reg.y}) -
                  $signed({anchor_y_reg[POS_W-1], anchor_y_reg});
        dx_sq   = dx * dx;
        dy_sq   = dy * dy;
        e_wait  = it_reg.now_ms - wait_start_reg;
        e_drag  = it_reg.now_ms - drag_start_reg;
        e_hover = hovering_reg ? (it_reg.now_ms - hover_start_reg) : '0;
        dsum    = {2'b00, dx2_reg} + {2'b00, dy2_reg};
        far     = dsum > {14'd0, ss_reg};
        moved   = dsum > {12'd0, ss_reg, 2'b00};
    end

    // repeat count for scroll types
    always_comb begin
        reps = REP_W'(1);
        if (cur_type_reg[TYPE_W-1:2] == 2'b01) begin
            reps = cfg.scroll_repeat;
            if (reps == '0) begin
                reps = REP_W'(1);
            end
            if (reps > REP_W'(REPEAT_CAP)) begin
                reps = REP_W'(REPEAT_CAP);
            end
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    // sequencer
    always_comb begin
        state_next       = state_reg;
        armed_next       = armed_reg;
        waiting_next     = waiting_reg;
        hovering_next    = hovering_reg;
        drag_held_next   = drag_held_reg;
        cur_type_next    = cur_type_reg;
        cur_mods_next    = cur_mods_reg;
        anchor_x_next    = anchor_x_reg;
        anchor_y_next    = anchor_y_reg;
        hover_start_next = hover_start_reg;
        wait_start_next  = wait_start_reg;
        drag_start_next  = drag_start_reg;
        it_next          = it_reg;
        dx2_next         = dx2_reg;
        dy2_next         = dy2_reg;
        ss_next          = ss_reg;
        timed_next       = timed_reg;
        drag_to_next     = drag_to_reg;
        fire_next        = fire_reg;
        el_next          = el_reg;
        em_type_next     = em_type_reg;
        em_mods_next     = em_mods_reg;
        prog_next        = prog_reg;
        prog_last_next   = prog_last_reg;
        rel_zero_next    = rel_zero_reg;
        rep_next         = rep_reg;
        q_pop            = 1'b0;
        div_start        = 1'b0;
        out_load         = 1'b0;
        res              = '0;
        res.pos_x        = it_reg.x;
        res.pos_y        = it_reg.y;
        res.out_type     = em_type_reg;

        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    it_next    = q_item;
                    state_next = S_SQ;
                end
            end

            // register squares and time tests
            S_SQ: begin
                dx2_next     = dx_sq[31:0];
                dy2_next     = dy_sq[31:0];
                ss_next      = (2*SENS_W)'(cfg.sensitivity_px) *
                               (2*SENS_W)'(cfg.sensitivity_px);
                timed_next   = e_wait >= TIME_W'(cfg.dwell_ms);
                drag_to_next = e_drag >= DRAG_HOLD_LIMIT_MS;
                fire_next    = e_hover >= TIME_W'(cfg.dwell_ms);
                el_next      = e_hover[DWELL_W-1:0];
                state_next   = S_DEC;
            end

            // decide the outcome and update the dwell state
            S_DEC: begin
                em_type_next = cur_type_reg;
                em_mods_next = cur_mods_reg;
                state_next   = S_IDLE;
                if (it_reg.is_arm) begin
                    if (drag_held_reg) begin
                        rel_zero_next = 1'b0;
                        state_next    = S_REL;
                    end
                    cur_type_next    = it_reg.arm_type;
                    cur_mods_next    = it_reg.arm_mods;
                    armed_next       = 1'b1;
                    waiting_next     = 1'b0;
                    hovering_next    = 1'b0;
                    drag_held_next   = 1'b0;
                    anchor_x_next    = it_reg.x;
                    anchor_y_next    = it_reg.y;
                    hover_start_next = it_reg.now_ms;
                end else if (it_reg.is_disarm) begin
                    rel_zero_next  = 1'b1;
                    state_next     = drag_held_reg ? S_REL : S_ZERO;
                    drag_held_next = 1'b0;
                    armed_next     = 1'b0;
                    waiting_next   = 1'b0;
                    hovering_next  = 1'b0;
                end else if (armed_reg) begin
                    if (waiting_reg) begin
                        // leave the wait on movement or after one dwell period
                        if (moved || timed_reg) begin
                            waiting_next     = 1'b0;
                            hovering_next    = 1'b0;
                            anchor_x_next    = it_reg.x;
                            anchor_y_next    = it_reg.y;
                            hover_start_next = it_reg.now_ms;
                            if (!moved) begin
                                armed_next = 1'b0;
                                state_next = S_ZERO;
                            end
                        end
                    end else if (drag_held_reg && drag_to_reg) begin
                        // forced drag release
                        cur_type_next   = (cur_type_reg == TYPE_LEFT_UP) ?
                                          TYPE_LEFT_DOWN : TYPE_RIGHT_DOWN;
                        drag_held_next  = 1'b0;
                        waiting_next    = 1'b1;
                        hovering_next   = 1'b0;
                        wait_start_next = it_reg.now_ms;
                        rel_zero_next   = 1'b1;
                        state_next      = S_REL;
                    end else if (far) begin
                        anchor_x_next    = it_reg.x;
                        anchor_y_next    = it_reg.y;
                        hovering_next    = 1'b0;
                        hover_start_next = it_reg.now_ms;
                        state_next       = S_ZERO;
                    end else begin
                        hovering_next = 1'b1;
                        if (!hovering_reg) begin
                            hover_start_next = it_reg.now_ms;
                        end
                        if (fire_reg) begin
                            prog_next      = PROG_FULL;
                            prog_last_next = 1'b0;
                            rep_next       = reps;
                            state_next     = S_PROG;
                            anchor_x_next  = it_reg.x;
                            anchor_y_next  = it_reg.y;
                            hovering_next  = 1'b0;
                            if (cur_type_reg == TYPE_LEFT_DOWN ||
                                cur_type_reg == TYPE_RIGHT_DOWN) begin
                                // down click starts a drag
                                cur_type_next   = cur_type_reg + 1'b1;
                                drag_held_next  = 1'b1;
                                drag_start_next = it_reg.now_ms;
                            end else begin
                                if ((cur_type_reg == TYPE_LEFT_UP ||
                                     cur_type_reg == TYPE_RIGHT_UP) && drag_held_reg) begin
                                    cur_type_next  = cur_type_reg - 1'b1;
                                    drag_held_next = 1'b0;
                                end
                                waiting_next    = 1'b1;
                                wait_start_next = it_reg.now_ms;
                            end
                        end else begin
                            prog_last_next = 1'b1;
                            div_start      = 1'b1;
                            state_next     = S_DIV;
                        end
                    end
                end
            end

            S_DIV: begin
                if (div_done) begin
                    prog_next  = {1'b0, div_quo};
                    state_next = S_PROG;
                end
            end

            // release click of a held drag
            S_REL: begin
                res.kind          = KIND_CLICK;
                res.out_modifiers = em_mods_reg;
                res.last          = !rel_zero_reg;
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = rel_zero_reg ? S_ZERO : S_IDLE;
                end
            end

            S_PROG: begin
                res          = '0;
                res.kind     = KIND_PROGRESS;
                res.progress = prog_reg;
                res.last     = prog_last_reg;
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = prog_last_reg ? S_IDLE : S_ABOUT;
                end
            end

            S_ABOUT: begin
                res.kind = KIND_ABOUT;
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_CLICK;
                end
            end

            S_CLICK: begin
                res.kind          = KIND_CLICK;
                res.out_modifiers = em_mods_reg;
                if (out_free) begin
                    out_load = 1'b1;
                    rep_next = rep_reg - 1'b1;
                    if (rep_reg == REP_W'(1)) begin
                        state_next = S_FIRED;
                    end
                end
            end

            S_FIRED: begin
                res.kind = KIND_FIRED;
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_ZERO;
                end
            end

            S_ZERO: begin
                res      = '0;
                res.kind = KIND_PROGRESS;
                res.last = 1'b1;
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and dwell state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            armed_reg       <= 1'b0;
            waiting_reg     <= 1'b0;
            hovering_reg    <= 1'b0;
            drag_held_reg   <= 1'b0;
            cur_type_reg    <= '0;
            cur_mods_reg    <= '0;
            anchor_x_reg    <= '0;
            anchor_y_reg    <= '0;
            hover_start_reg <= '0;
            wait_start_reg  <= '0;
            drag_start_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            armed_reg       <= armed_next;
            waiting_reg     <= waiting_next;
            hovering_reg    <= hovering_next;
            drag_held_reg   <= drag_held_next;
            cur_type_reg    <= cur_type_next;
            cur_mods_reg    <= cur_mods_next;
            anchor_x_reg    <= anchor_x_next;
            anchor_y_reg    <= anchor_y_next;
            hover_start_reg <= hover_start_next;
            wait_start_reg  <= wait_start_next;
            drag_start_reg  <= drag_start_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // working payload
    always_ff @(posedge aclk) begin
        it_reg        <= it_next;
        dx2_reg       <= dx2_next;
        dy2_reg       <= dy2_next;
        ss_reg        <= ss_next;
        timed_reg     <= timed_next;
        drag_to_reg   <= drag_to_next;
        fire_reg      <= fire_next;
        el_reg        <= el_next;
        em_type_reg   <= em_type_next;
        em_mods_reg   <= em_mods_next;
        prog_reg      <= prog_next;
        prog_last_reg <= prog_last_next;
        rel_zero_reg  <= rel_zero_next;
        rep_reg       <= rep_next;
        if (out_load) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a held drag only exists armed, outside a wait, on an up type
    a_drag_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        drag_held_reg |-> armed_reg && !waiting_reg &&
        (cur_type_reg == TYPE_LEFT_UP || cur_type_reg == TYPE_RIGHT_UP))
        else $error("drag held in an inconsistent mode");

    // a wait excludes hovering and needs the block armed
    a_wait_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        waiting_reg |-> armed_reg && !hovering_reg)
        else $error("waiting while hovering or disarmed");

    // the divide leads only to the progress result
    a_div_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |=> (state_reg == S_DIV || state_reg == S_PROG))
        else $error("divide left to an unexpected state");

    // progress never exceeds full scale
    a_prog_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.kind == KIND_PROGRESS) |-> m_data_reg.progress <= PROG_FULL)
        else $error("progress out of range");

    // work starts only on a request taken from the queue
    a_take_then_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SQ) |-> $past(q_pop && q_valid))
        else $error("work started without a queued request");

endmodule

FILE: rtl/dwell_click_controller.sv
// Dwell-click controller: a request passes the front-end queue and the back-end states
// S_SQ and S_DEC before its first result, and S_DIV when the progress fraction needs the
// 8-step divider. Results then leave one per cycle while m_ready is high. The back end
// works on one item at a time; a two-entry queue takes requests meanwhile.
// Reset (aresetn low, synchronous) disarms the block, clears the dwell state and the
// queue, and restores the register defaults; no clearing pass is needed.
module dwell_click_controller (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  dcc_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output dcc_pkg::out_item_t            m_data,
    input  logic                          cfg_we,
    input  logic [dcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dcc_pkg::DWELL_W-1:0]   cfg_wdata
);
    import dcc_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       q_valid;
    logic       q_pop;
    dec_item_t  q_item;

    // configuration registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_DWELL:  cfg_next.dwell_ms       = cfg_wdata;
                CFG_SENS:   cfg_next.sensitivity_px = cfg_wdata[SENS_W-1:0];
                CFG_REPEAT: cfg_next.scroll_repeat  = cfg_wdata[REP_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dwell_ms       <= DWELL_RESET;
            cfg_reg.sensitivity_px <= SENS_RESET;
            cfg_reg.scroll_repeat  <= REPEAT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    dcc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    dcc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
